FILE: design/cnd_pkg.sv
// Shared constants and types for the Crank-Nicolson diffusion step.
`timescale 1ns / 1ps
`default_nettype none
package cnd_pkg;
    localparam int GridPointsDefault = 64;
    localparam logic [19:0] RatioReset = 20'd14746;
    localparam int ValueW = 32;
    localparam int RatioW = 20;
    localparam int IndexW = 7;
    localparam int NumW = 54;   // dividend magnitude width
    localparam int DenW = 22;   // divisor width

    typedef struct packed {
        logic start;
        logic signed_result;
    } div_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647)
            res = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            res = 32'sh80000000;
        else
            res = v[31:0];
        return res;
    endfunction

    // floor((p + 2^15) / 2^16)
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd32768;
        return s >>> 16;
    endfunction
endpackage
`default_nettype wire

FILE: design/cnd_divider.sv
// Restoring serial divider, one quotient bit per cycle, truncation toward zero.
`timescale 1ns / 1ps
`default_nettype none
module cnd_divider
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic signed [63:0]     numer,
    input  wire logic [cnd_pkg::DenW-1:0] denom,
    output logic                        busy,
    output logic signed [63:0]          quot
);
    import cnd_pkg::*;

    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0]   q_reg, q_next;
    logic [DenW:0]     rem_reg, rem_next;
    logic [DenW-1:0]   den_reg;
    logic              neg_reg;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DenW:0]     trial;
    logic [63:0]       mag;

    always_comb
    begin
        mag = numer[63] ? 64'(-numer) : 64'(numer);
        trial = {rem_reg[DenW-1:0], q_reg[NumW-1]};
        q_next = {q_reg[NumW-2:0], 1'b0};
        rem_next = trial;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next[0] = 1'b1;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                busy_next = 1'b0;
        end
        else
        begin
            q_next = q_reg;
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= CntW'(NumW);
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= mag[NumW-1:0];
            rem_reg <= '0;
            den_reg <= denom;
            neg_reg <= numer[63];
        end
        else
        begin
            q_reg <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quot = neg_reg ? -$signed({10'd0, q_reg}) : $signed({10'd0, q_reg});
endmodule
`default_nettype wire

FILE: design/cnd_grid_mem.sv
// Single-port-write, registered-read memory for 32-bit words.
`timescale 1ns / 1ps
`default_nettype none
module cnd_grid_mem
#(
    parameter int DEPTH = cnd_pkg::GridPointsDefault
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [31:0]              wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [31:0]                   rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: design/crank_nicolson_diffusion_step.sv
// Top level of the Crank-Nicolson 1-D diffusion step with Thomas solver.
// Sequence: a final load item with at least three points loaded starts a forward sweep that,
// per interior point, reads three grid words, forms the right-hand side and runs two serial
// divisions of 54 quotient bits on one divider, each with start and write-back. Back
// substitution then reads, multiplies and writes each point; each result is read, then output.
// Throughput: one step at a time; no input is taken until the last result item is issued.
// Reset: load count cleared, ratio set to 14746; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module crank_nicolson_diffusion_step
#(
    parameter int GRID_POINTS = cnd_pkg::GridPointsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [19:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // point_value [31:0]
    input  wire logic        s_tlast,   // final_point
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // new_value [31:0], point_index [38:32], zero
    output logic             m_tlast    // last_result
);
    import cnd_pkg::*;

    localparam int AW = $clog2(GRID_POINTS);
    localparam int CW = $clog2(GRID_POINTS + 1);

    // Sequencer states
    localparam logic [3:0] S_LOAD = 4'd0, S_RD0 = 4'd1, S_RD1 = 4'd2, S_RD2 = 4'd3,
                           S_RHS = 4'd4, S_DIVE = 4'd5, S_WE = 4'd6, S_DIVD = 4'd7,
                           S_WD = 4'd8, S_BRD = 4'd9, S_BMUL = 4'd10, S_BW = 4'd11,
                           S_OUT = 4'd12, S_RD3 = 4'd13, S_ORD = 4'd14;

    logic [3:0]  st_reg, st_next;
    logic [19:0] ratio_reg;
    logic [CW-1:0] cnt_reg;           // points loaded
    logic [AW-1:0] n_reg;             // index of last grid point (n-1)
    logic [AW-1:0] k_reg;             // equation index
    logic signed [31:0] ul_reg, uc_reg, ur_reg;
    logic signed [31:0] d_reg;        // d[k], right-hand side of equation k
    logic [31:0] eprev_reg;           // e[k-1]
    logic signed [31:0] dprev_reg;    // d'[k-1], then x[k] during back pass
    logic [DenW-1:0] den_reg;
    logic signed [31:0] xcur_reg;

    // grid memory
    logic          g_we;
    logic [AW-1:0] g_wa, g_ra;
    logic [31:0]   g_rd;
    // coefficient and solution memories
    logic          e_we, x_we;
    logic [AW-1:0] e_wa, e_ra, x_wa, x_ra;
    logic [31:0]   e_wd, x_wd, e_rd, x_rd;

    cnd_grid_mem #(.DEPTH(GRID_POINTS)) u_grid
        (.clk(clk), .we(g_we), .waddr(g_wa), .wdata(s_tdata), .raddr(g_ra), .rdata(g_rd));
    cnd_grid_mem #(.DEPTH(GRID_POINTS)) u_coef
        (.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
    cnd_grid_mem #(.DEPTH(GRID_POINTS)) u_soln
        (.clk(clk), .we(x_we), .waddr(x_wa), .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));

    logic               div_start, div_busy;
    logic signed [63:0] div_num, div_q;
    cnd_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .numer(div_num),
                       .denom(den_reg), .busy(div_busy), .quot(div_q));

    logic signed [63:0] r64, acc, prod;
    logic               accept;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (st_reg == S_LOAD);
    assign r64 = $signed({44'd0, ratio_reg});
    assign g_we = accept;
    assign g_wa = (cnt_reg >= CW'(GRID_POINTS)) ? AW'(GRID_POINTS - 1) : cnt_reg[AW-1:0];

    // Grid reads: u[k], u[k+1], u[k+2] through three consecutive addresses.
    always_comb
    begin
        g_ra = k_reg;
        if (st_reg == S_RD1)
            g_ra = AW'(k_reg + 1'b1);
        else if (st_reg == S_RD2)
            g_ra = AW'(k_reg + 2'd2);
    end

    // Right-hand side: r*(u[j-1]+u[j+1]) + (1-2r)u[j], boundary terms doubled.
    always_comb
    begin
        acc = r64 * (64'(ul_reg) + 64'(ur_reg)) + (64'sd65536 - 2 * r64) * 64'(uc_reg);
        if (k_reg == '0)
            acc = acc + r64 * 64'(ul_reg);
        if (k_reg == AW'(n_reg - 2'd2))
            acc = acc + r64 * 64'(ur_reg);
    end

    // One product shared by the back pass (e[k-1]*x[k]) and the forward pivot term (r*e[k-1]).
    always_comb
    begin
        if (st_reg == S_BMUL)
            prod = $signed({32'd0, e_rd}) * 64'(dprev_reg);
        else
            prod = r64 * $signed({32'd0, eprev_reg});
    end

    logic signed [63:0] dnum;
    assign dnum = (64'(d_reg) <<< 16) + ((k_reg != '0) ? r64 * 64'(dprev_reg) : 64'sd0);

    always_comb
    begin
        div_start = 1'b0;
        div_num = 64'(dnum);
        e_we = 1'b0;
        e_wa = k_reg;
        e_wd = div_q[31:0];
        x_we = 1'b0;
        x_wa = k_reg;
        x_wd = sat32(div_q);
        e_ra = k_reg;
        x_ra = k_reg;
        st_next = st_reg;
        case (st_reg)
            S_LOAD:
                if (accept && s_tlast)
                    st_next = (g_wa >= AW'(2)) ? S_RD0 : S_LOAD;
            S_RD0:  st_next = S_RD1;
            S_RD1:  st_next = S_RD2;
            S_RD2:  st_next = S_RD3;
            S_RD3:  st_next = S_RHS;
            S_RHS:  st_next = S_DIVE;
            S_DIVE:
            begin
                div_start = 1'b1;
                div_num = r64 <<< 16;
                st_next = S_WE;
            end
            S_WE:
                if (!div_busy)
                begin
                    e_we = 1'b1;
                    st_next = S_DIVD;
                end
            S_DIVD:
            begin
                div_start = 1'b1;
                st_next = S_WD;
            end
            S_WD:
                if (!div_busy)
                begin
                    x_we = 1'b1;
                    if (k_reg != AW'(n_reg - 2'd2))
                        st_next = S_RD0;
                    else
                        st_next = (k_reg == '0) ? S_ORD : S_BRD;
                end
            S_BRD:  st_next = S_BMUL;
            S_BMUL: st_next = S_BW;
            S_BW:
            begin
                x_we = 1'b1;
                x_wa = AW'(k_reg - 1'b1);
                x_wd = xcur_reg;
                st_next = (k_reg == AW'(1)) ? S_ORD : S_BRD;
            end
            S_ORD:  st_next = S_OUT;
            S_OUT:
                if (m_tready || !m_tvalid)
                    st_next = (k_reg == AW'(n_reg - 2'd2)) ? S_LOAD : S_ORD;
            default: st_next = S_LOAD;
        endcase
        if (st_reg == S_BRD || st_reg == S_BMUL)
        begin
            e_ra = AW'(k_reg - 1'b1);
            x_ra = AW'(k_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_LOAD;
            ratio_reg <= RatioReset;
            cnt_reg <= '0;
            m_tvalid <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
                ratio_reg <= cfg_wdata;
            if (accept)
                cnt_reg <= s_tlast ? '0 :
                           ((cnt_reg < CW'(GRID_POINTS)) ? CW'(cnt_reg + 1'b1) : cnt_reg);
            if (st_reg == S_OUT && (m_tready || !m_tvalid))
                m_tvalid <= 1'b1;
            else if (m_tready)
                m_tvalid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_LOAD:
                if (accept && s_tlast)
                begin
                    n_reg <= g_wa;
                    k_reg <= '0;
                end
            S_RD1: ul_reg <= g_rd;
            S_RD2: uc_reg <= g_rd;
            S_RD3: ur_reg <= g_rd;
            S_RHS:
            begin
                d_reg <= sat32(rnd16(acc));
                den_reg <= (k_reg == '0) ? DenW'(65536 + 2 * {2'd0, ratio_reg})
                         : DenW'(64'sd65536 + 2 * r64 - rnd16(prod));
            end
            S_WE:
                if (!div_busy)
                    eprev_reg <= div_q[31:0];
            S_WD:
                if (!div_busy)
                begin
                    dprev_reg <= sat32(div_q);
                    if (k_reg != AW'(n_reg - 2'd2))
                        k_reg <= AW'(k_reg + 1'b1);
                end
            S_BMUL: xcur_reg <= sat32(64'($signed(x_rd)) + rnd16(prod));
            S_BW:
            begin
                dprev_reg <= xcur_reg;
                k_reg <= AW'(k_reg - 1'b1);
            end
            S_OUT:
                if (m_tready || !m_tvalid)
                begin
                    // The solution store is read at k, so its word is ready here.
                    m_tdata <= {1'b0, IndexW'(k_reg + 1'b1), x_rd};
                    m_tlast <= (k_reg == AW'(n_reg - 2'd2));
                    if (k_reg != AW'(n_reg - 2'd2))
                        k_reg <= AW'(k_reg + 1'b1);
                end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: sim/tb_crank_nicolson_diffusion_step.sv
// Self-checking testbench for the Crank-Nicolson diffusion step block.
`timescale 1ns / 1ps
`default_nettype none
module tb_crank_nicolson_diffusion_step;
    import cnd_pkg::*;

    localparam int Points = 64;
    localparam int SettleCycles = 400;   // covers a solve that emits nothing
    localparam int LongHold = 3000;

    // One updated interior point as the block should emit it.
    typedef struct {
        logic [31:0] value;
        logic [6:0]  idx;
        logic        last;
    } point_result_t;

    // One row of the directed table. A new ratio is written before the row
    // when new_ratio is not negative; typed_ok marks a grid point whose
    // updated value is known in advance.
    typedef struct {
        int          new_ratio;
        logic [31:0] value;
        bit          fin;
        bit          typed_ok;
        logic [31:0] typed_val;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [19:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    crank_nicolson_diffusion_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Predictor state: its own copy of the ratio and the stores.
    logic [19:0]   ratio_now;
    longint        grid_vals [Points];
    longint        sweep_e   [Points-2];
    longint        sweep_x   [Points-2];
    int            loaded;
    bit            typed_ok  [Points];
    logic [31:0]   typed_val [Points];
    point_result_t pending_points[$];
    int            errors;
    int            sent;
    bit            long_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The run is ended here if the block hangs.
    initial
    begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint rnd_q16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp32(input longint v);
        longint res;
        res = v;
        if (v > 64'sd2147483647)
            res = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            res = -64'sd2147483648;
        return res;
    endfunction

    // Loads one grid point; on the final point of a grid of three or more points it solves the step
    // and queues the updated interior values in grid order.
    task automatic absorb_point(input logic [31:0] val, input bit fin);
        int            slot;
        int            n;
        int            m;
        longint        r;
        longint        acc;
        longint        d;
        longint        den;
        longint        num;
        point_result_t res;
        slot = (loaded < Points) ? loaded : Points - 1;
        grid_vals[slot] = longint'(signed'(val));
        if (loaded < Points)
            loaded++;
        if (!fin)
            return;
        n = loaded;
        loaded = 0;
        if (n >= 3)
        begin
            m = n - 2;
            r = longint'(ratio_now);
            // Right-hand side with the boundary terms, then the forward sweep.
            for (int k = 0; k < m; k++)
            begin
                acc = r * (grid_vals[k] + grid_vals[k+2]) + (65536 - 2 * r) * grid_vals[k+1];
                if (k == 0)
                    acc += r * grid_vals[0];
                if (k == m - 1)
                    acc += r * grid_vals[n-1];
                d = clamp32(rnd_q16(acc));
                den = 65536 + 2 * r;
                num = d * 65536;
                if (k > 0)
                begin
                    den -= rnd_q16(r * sweep_e[k-1]);
                    num += r * sweep_x[k-1];
                end
                if (den < 1)
                    den = 1;
                sweep_e[k] = (r * 65536) / den;
                sweep_x[k] = clamp32(num / den);
            end
            for (int k = m - 1; k > 0; k--)
                sweep_x[k-1] = clamp32(sweep_x[k-1] + rnd_q16(sweep_e[k-1] * sweep_x[k]));
            for (int k = 0; k < m; k++)
            begin
                res.value = typed_ok[k+1] ? typed_val[k+1] : sweep_x[k][31:0];
                res.idx = 7'(k + 1);
                res.last = (k == m - 1);
                pending_points.push_back(res);
            end
        end
        for (int i = 0; i < Points; i++)
            typed_ok[i] = 1'b0;
    endtask

    // Offers one item after a random gap and waits for the handshake.
    task automatic send_point(input logic [31:0] val, input bit fin);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= val;
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_point(val, fin);
        sent++;
    endtask

    // Waits until the block is idle, then writes the ratio.
    task automatic write_ratio(input logic [19:0] val);
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        ratio_now = val;
    endtask

    // Result side: random stalls, one long hold-off on request, and the
    // field-by-field check against the oldest expected point.
    initial
    begin
        int            gap;
        point_result_t want;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LongHold) @(posedge clk);
                long_hold_req = 1'b0;
            end
            gap = $urandom_range(0, 7);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected item, actual data %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (m_tdata !== {1'b0, want.idx, want.value} || m_tlast !== want.last)
                begin
                    $display("%0t: mismatch, expected value %h index %0d last %b, actual data %h last %b",
                             $time, want.value, want.idx, want.last, m_tdata, m_tlast);
                    errors++;
                end
            end
        end
    end

    dir_row_t dir_rows[$];

    initial
    begin
        int       len;
        int       pick;
        logic [31:0] v;
        errors = 0;
        sent = 0;
        loaded = 0;
        long_hold_req = 1'b0;
        ratio_now = RatioReset;
        for (int i = 0; i < Points; i++)
            typed_ok[i] = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset ratio: steps too short to have an interior, then full-scale values.
        dir_rows = '{
            '{-1, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h0005_0000, 1'b1, 1'b0, 32'h0},
            '{-1, 32'h7fff_ffff, 1'b1, 1'b0, 32'h0},
            '{-1, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h7fff_ffff, 1'b1, 1'b0, 32'h0},
            // A zero ratio leaves every interior value untouched.
            '{0,  32'h1234_5678, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
            '{-1, 32'h7fff_ffff, 1'b0, 1'b1, 32'h7fff_ffff},
            '{-1, 32'hffff_ffff, 1'b0, 1'b1, 32'hffff_ffff},
            '{-1, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
            // Largest ratio, with alternating extremes that drive saturation.
            '{1048575, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
            '{-1, 32'h0001_0000, 1'b1, 1'b0, 32'h0}
        };
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].new_ratio >= 0)
                write_ratio(20'(dir_rows[i].new_ratio));
            if (dir_rows[i].typed_ok)
            begin
                typed_ok[loaded] = 1'b1;
                typed_val[loaded] = dir_rows[i].typed_val;
            end
            send_point(dir_rows[i].value, dir_rows[i].fin);
        end

        // Random steps: mostly short grids, a few too short, a few near or over the grid depth.
        long_hold_req = 1'b1;
        while (sent < 180)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, 5);
                if (pick == 0)
                    write_ratio(20'd0);
                else if (pick == 1)
                    write_ratio(20'hfffff);
                else if (pick == 2)
                    write_ratio(20'($urandom));
                else
                    write_ratio(20'($urandom_range(0, 65536)));
            end
            pick = $urandom_range(0, 15);
            if (pick == 0)
                len = $urandom_range(1, 2);
            else if (pick == 1)
                len = $urandom_range(60, 68);
            else
                len = $urandom_range(3, 10);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    v = 32'h7fff_ffff;
                else if (pick == 1)
                    v = 32'h8000_0000;
                else if (pick < 5)
                    v = $urandom;
                else
                    v = 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
                send_point(v, i == len - 1);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
